FILE: design/cltr_pkg.sv
// cltr_pkg: shared types, constants and lookup functions of the transliterator
// forward rom, reverse digraph/trigraph tables, symbol classification
// no dependencies
package cltr_pkg;

    localparam int unsigned VARIANT_COUNT    = 3;
    localparam int unsigned CYRILLIC_LETTERS = 32;
    localparam int unsigned LATIN_LETTERS    = 26;
    localparam int unsigned CP_W             = 21;
    localparam int unsigned ASCII_W          = 7;

    localparam logic [CP_W-1:0] CYR_BASE = 21'h000430;
    localparam logic [CP_W-1:0] LAT_BASE = 21'h000061;

    // variant codes
    localparam logic [1:0] VAR_PLAIN    = 2'd0;
    localparam logic [1:0] VAR_DIGRAPH  = 2'd1;
    localparam logic [1:0] VAR_TRIGRAPH = 2'd2;

    // erase codes
    localparam logic [1:0] ERASE_NONE = 2'd0;
    localparam logic [1:0] ERASE_ONE  = 2'd1;
    localparam logic [1:0] ERASE_TWO  = 2'd2;

    // context fill codes
    localparam logic [1:0] FILL_EMPTY = 2'd0;
    localparam logic [1:0] FILL_ONE   = 2'd1;
    localparam logic [1:0] FILL_TWO   = 2'd2;

    typedef enum logic [1:0] {
        CLS_CYR   = 2'd0,
        CLS_LAT   = 2'd1,
        CLS_OTHER = 2'd2
    } sym_class_t;

    typedef struct packed {
        logic [CP_W-1:0] symbol;
        logic            last_in_word;
    } item_t;

    typedef struct packed {
        logic [4:0] recent;
        logic [4:0] earlier;
        logic [1:0] fill;
    } ctx_t;

    typedef struct packed {
        logic [1:0]      variant_index;
        logic [1:0]      erase_count;
        logic [1:0]      append_length;
        logic [CP_W-1:0] char_first;
        logic [CP_W-1:0] char_second;
        logic [CP_W-1:0] char_third;
        logic            final_variant;
    } edit_t;

    typedef struct packed {
        logic [1:0]         len;
        logic [ASCII_W-1:0] c0;
        logic [ASCII_W-1:0] c1;
        logic [ASCII_W-1:0] c2;
    } fwd_t;

    typedef struct packed {
        logic       hit;
        logic [4:0] idx;
    } rev_t;

    function automatic sym_class_t sym_class(logic [CP_W-1:0] sym);
        sym_class_t cls;
        if (sym >= CYR_BASE && sym < CYR_BASE + CP_W'(CYRILLIC_LETTERS))
            cls = CLS_CYR;
        else if (sym >= LAT_BASE && sym < LAT_BASE + CP_W'(LATIN_LETTERS))
            cls = CLS_LAT;
        else
            cls = CLS_OTHER;
        return cls;
    endfunction

    function automatic fwd_t str1(byte unsigned a);
        return '{len: 2'd1, c0: ASCII_W'(a), c1: '0, c2: '0};
    endfunction

    function automatic fwd_t str2(byte unsigned a, byte unsigned b);
        return '{len: 2'd2, c0: ASCII_W'(a), c1: ASCII_W'(b), c2: '0};
    endfunction

    function automatic fwd_t str3(byte unsigned a, byte unsigned b, byte unsigned c);
        return '{len: 2'd3, c0: ASCII_W'(a), c1: ASCII_W'(b), c2: ASCII_W'(c)};
    endfunction

    // forward rom: cyrillic letter index and variant to latin string
    function automatic fwd_t fwd_entry(logic [4:0] idx, logic [1:0] v);
        fwd_t e;
        unique case (idx)
            5'd0:  e = str1("a");
            5'd1:  e = str1("b");
            5'd2:  e = str1("v");
            5'd3:  e = str1("g");
            5'd4:  e = str1("d");
            5'd5:  e = str1("e");
            5'd6:  e = str2("z", "h");
            5'd7:  e = str1("z");
            5'd8:  e = str1("i");
            5'd9:  e = (v == VAR_DIGRAPH) ? str1("j") : str1("y");
            5'd10: e = str1("k");
            5'd11: e = str1("l");
            5'd12: e = str1("m");
            5'd13: e = str1("n");
            5'd14: e = str1("o");
            5'd15: e = str1("p");
            5'd16: e = str1("r");
            5'd17: e = str1("s");
            5'd18: e = str1("t");
            5'd19: e = str1("u");
            5'd20: e = str1("f");
            5'd21: e = (v == VAR_PLAIN) ? str2("k", "h")
                     : ((v == VAR_DIGRAPH) ? str1("h") : str1("x"));
            5'd22: e = str1("c");
            5'd23: e = str2("c", "h");
            5'd24: e = str2("s", "h");
            5'd25: e = (v == VAR_DIGRAPH) ? str1("w") : str3("s", "h", "h");
            5'd26: e = str3("j", "h", "h");
            5'd27: e = str2("i", "h");
            5'd28: e = (v == VAR_DIGRAPH) ? str1("'") : str2("j", "h");
            5'd29: e = (v == VAR_DIGRAPH) ? str2("j", "e") : str2("e", "h");
            5'd30: e = (v == VAR_DIGRAPH) ? str2("y", "u") : str2("j", "u");
            5'd31: e = (v == VAR_TRIGRAPH) ? str1("q")
                     : ((v == VAR_DIGRAPH) ? str2("y", "a") : str2("j", "a"));
        endcase
        return e;
    endfunction

    // latin letter index of an ascii letter
    function automatic logic [4:0] li(byte unsigned c);
        return 5'(c - "a");
    endfunction

    // single latin letter to cyrillic letter index, last rom match wins
    function automatic logic [4:0] rev_single(logic [4:0] l);
        logic [4:0] idx;
        unique case (l)
            li("a"): idx = 5'd0;
            li("b"): idx = 5'd1;
            li("c"): idx = 5'd22;
            li("d"): idx = 5'd4;
            li("e"): idx = 5'd5;
            li("f"): idx = 5'd20;
            li("g"): idx = 5'd3;
            li("h"): idx = 5'd21;
            li("i"): idx = 5'd8;
            li("j"): idx = 5'd9;
            li("k"): idx = 5'd10;
            li("l"): idx = 5'd11;
            li("m"): idx = 5'd12;
            li("n"): idx = 5'd13;
            li("o"): idx = 5'd14;
            li("p"): idx = 5'd15;
            li("q"): idx = 5'd31;
            li("r"): idx = 5'd16;
            li("s"): idx = 5'd17;
            li("t"): idx = 5'd18;
            li("u"): idx = 5'd19;
            li("v"): idx = 5'd2;
            li("w"): idx = 5'd25;
            li("x"): idx = 5'd21;
            li("y"): idx = 5'd9;
            li("z"): idx = 5'd7;
            default: idx = 5'd0;
        endcase
        return idx;
    endfunction

    function automatic rev_t rev_pair(logic [4:0] a, logic [4:0] b);
        rev_t r;
        unique case ({a, b})
            {li("z"), li("h")}: r = '{hit: 1'b1, idx: 5'd6};
            {li("k"), li("h")}: r = '{hit: 1'b1, idx: 5'd21};
            {li("c"), li("h")}: r = '{hit: 1'b1, idx: 5'd23};
            {li("s"), li("h")}: r = '{hit: 1'b1, idx: 5'd24};
            {li("i"), li("h")}: r = '{hit: 1'b1, idx: 5'd27};
            {li("j"), li("h")}: r = '{hit: 1'b1, idx: 5'd28};
            {li("e"), li("h")}: r = '{hit: 1'b1, idx: 5'd29};
            {li("j"), li("e")}: r = '{hit: 1'b1, idx: 5'd29};
            {li("j"), li("u")}: r = '{hit: 1'b1, idx: 5'd30};
            {li("y"), li("u")}: r = '{hit: 1'b1, idx: 5'd30};
            {li("j"), li("a")}: r = '{hit: 1'b1, idx: 5'd31};
            {li("y"), li("a")}: r = '{hit: 1'b1, idx: 5'd31};
            default:            r = '{hit: 1'b0, idx: 5'd0};
        endcase
        return r;
    endfunction

    function automatic rev_t rev_triple(logic [4:0] a, logic [4:0] b, logic [4:0] c);
        rev_t r;
        unique case ({a, b, c})
            {li("s"), li("h"), li("h")}: r = '{hit: 1'b1, idx: 5'd25};
            {li("j"), li("h"), li("h")}: r = '{hit: 1'b1, idx: 5'd26};
            default:                     r = '{hit: 1'b0, idx: 5'd0};
        endcase
        return r;
    endfunction

endpackage

FILE: design/cltr_sym_if.sv
// cltr_sym_if: input channel, one code point per transaction
// depends on nothing
interface cltr_sym_if;
    logic        valid;
    logic        ready;
    logic [20:0] symbol;
    logic        last_in_word;

    modport source (output valid, output symbol, output last_in_word, input ready);
    modport sink   (input valid, input symbol, input last_in_word, output ready);
endinterface

FILE: design/cltr_edit_if.sv
// cltr_edit_if: result channel, one variant edit per transaction
// depends on nothing
interface cltr_edit_if;
    logic        valid;
    logic        ready;
    logic [1:0]  variant_index;
    logic [1:0]  erase_count;
    logic [1:0]  append_length;
    logic [20:0] char_first;
    logic [20:0] char_second;
    logic [20:0] char_third;
    logic        final_variant;

    modport source (output valid, output variant_index, output erase_count,
                    output append_length, output char_first, output char_second,
                    output char_third, output final_variant, input ready);
    modport sink   (input valid, input variant_index, input erase_count,
                    input append_length, input char_first, input char_second,
                    input char_third, input final_variant, output ready);
endinterface

FILE: design/cltr_edit_gen.sv
// cltr_edit_gen: builds the edit of one variant from the held item and context
// depends on cltr_pkg
module cltr_edit_gen
    import cltr_pkg::*;
(
    input  item_t      item,
    input  ctx_t       ctx,
    input  logic [1:0] variant,
    output edit_t      edit
);

    always_comb
    begin
        sym_class_t cls;
        fwd_t       fwd;
        rev_t       pair;
        rev_t       triple;
        logic [4:0] lat;
        logic [4:0] cyr;
        logic [4:0] hit_idx;

        cls     = sym_class(item.symbol);
        cyr     = 5'(item.symbol - CYR_BASE);
        lat     = 5'(item.symbol - LAT_BASE);
        fwd     = fwd_entry(cyr, variant);
        pair    = rev_pair(ctx.recent, lat);
        triple  = rev_triple(ctx.earlier, ctx.recent, lat);
        hit_idx = rev_single(lat);

        edit               = '0;
        edit.variant_index = variant;
        edit.final_variant = (variant == VAR_TRIGRAPH);

        unique case (cls)
            CLS_CYR:
            begin
                edit.erase_count   = ERASE_NONE;
                edit.append_length = fwd.len;
                edit.char_first    = CP_W'(fwd.c0);
                edit.char_second   = CP_W'(fwd.c1);
                edit.char_third    = CP_W'(fwd.c2);
            end
            CLS_LAT:
            begin
                edit.erase_count = ERASE_NONE;
                if (variant == VAR_DIGRAPH && ctx.fill != FILL_EMPTY && pair.hit)
                begin
                    hit_idx          = pair.idx;
                    edit.erase_count = ERASE_ONE;
                end
                else if (variant == VAR_TRIGRAPH && ctx.fill == FILL_TWO && triple.hit)
                begin
                    hit_idx          = triple.idx;
                    edit.erase_count = ERASE_TWO;
                end
                edit.append_length = 2'd1;
                edit.char_first    = CYR_BASE + CP_W'(hit_idx);
            end
            default:
            begin
                edit.erase_count   = ERASE_NONE;
                edit.append_length = 2'd1;
                edit.char_first    = item.symbol;
            end
        endcase
    end

endmodule

FILE: design/cltr_item_stage.sv
// cltr_item_stage: input register, variant counter and letter context
// depends on cltr_pkg, cltr_sym_if
module cltr_item_stage
    import cltr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    cltr_sym_if.sink    symbols,
    input  logic        issue,
    output logic        item_valid,
    output item_t       item,
    output logic [1:0]  variant,
    output ctx_t        ctx
);

    logic       item_valid_reg;
    logic       item_valid_next;
    logic [1:0] variant_reg;
    logic [1:0] variant_next;
    ctx_t       ctx_reg;
    ctx_t       ctx_next;
    item_t      item_reg;
    logic       accept;
    logic       last_issue;

    // item retires when its third edit moves to the output register
    assign last_issue    = issue && (variant_reg == VAR_TRIGRAPH);
    assign symbols.ready = !item_valid_reg || last_issue;
    assign accept        = symbols.valid && symbols.ready;

    always_comb
    begin
        item_valid_next = item_valid_reg;
        variant_next    = variant_reg;
        ctx_next        = ctx_reg;

        if (last_issue)
        begin
            item_valid_next = 1'b0;
            unique case (sym_class(item_reg.symbol))
                CLS_LAT:
                begin
                    ctx_next.recent = 5'(item_reg.symbol - LAT_BASE);
                    if (ctx_reg.fill != FILL_EMPTY)
                    begin
                        ctx_next.earlier = ctx_reg.recent;
                        ctx_next.fill    = FILL_TWO;
                    end
                    else
                    begin
                        ctx_next.fill = FILL_ONE;
                    end
                end
                default:
                begin
                    ctx_next.fill = FILL_EMPTY;
                end
            endcase
            if (item_reg.last_in_word)
                ctx_next.fill = FILL_EMPTY;
        end
        else if (issue)
        begin
            variant_next = variant_reg + 2'd1;
        end

        if (accept)
        begin
            item_valid_next = 1'b1;
            variant_next    = VAR_PLAIN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            variant_reg    <= VAR_PLAIN;
            ctx_reg        <= '0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            variant_reg    <= variant_next;
            ctx_reg        <= ctx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= '{symbol: symbols.symbol, last_in_word: symbols.last_in_word};
    end

    assign item_valid = item_valid_reg;
    assign item       = item_reg;
    assign variant    = variant_reg;
    assign ctx        = ctx_reg;

    a_variant_range: assert property (@(posedge clk) disable iff (!rst_n)
        variant_reg != 2'd3)
        else $error("variant counter out of range");

    a_new_item_starts_plain: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (item_valid_reg && variant_reg == VAR_PLAIN))
        else $error("accepted item does not start at the first variant");

    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        ctx_reg.fill != 2'd3)
        else $error("context fill out of range");

endmodule

FILE: design/cltr_out_stage.sv
// cltr_out_stage: result register that drives the edit channel
// depends on cltr_pkg, cltr_edit_if
module cltr_out_stage
    import cltr_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         load_valid,
    input  edit_t        edit,
    output logic         free,
    cltr_edit_if.source  edits
);

    logic  valid_reg;
    logic  valid_next;
    edit_t edit_reg;
    logic  load;

    assign free = !valid_reg || edits.ready;
    assign load = load_valid && free;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (edits.ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            edit_reg <= edit;
    end

    assign edits.valid         = valid_reg;
    assign edits.variant_index = edit_reg.variant_index;
    assign edits.erase_count   = edit_reg.erase_count;
    assign edits.append_length = edit_reg.append_length;
    assign edits.char_first    = edit_reg.char_first;
    assign edits.char_second   = edit_reg.char_second;
    assign edits.char_third    = edit_reg.char_third;
    assign edits.final_variant = edit_reg.final_variant;

    a_final_matches_variant: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (edit_reg.final_variant == (edit_reg.variant_index == VAR_TRIGRAPH)))
        else $error("final flag disagrees with variant index");

    a_append_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (edit_reg.append_length != 2'd0))
        else $error("edit appends nothing");

    a_variant_order: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && edits.ready && !edit_reg.final_variant) |=>
            (!valid_reg || edit_reg.variant_index == $past(edit_reg.variant_index) + 2'd1))
        else $error("edits of one item leave out of order");

endmodule

FILE: design/cyrillic_latin_transliterator_unit.sv
// cyrillic_latin_transliterator_unit: top level of the transliterator
// depends on cltr_pkg, cltr_sym_if, cltr_edit_if, cltr_item_stage,
// cltr_edit_gen, cltr_out_stage
//
//  channel   dir  payload                                         per transaction
//  symbols   in   symbol[20:0], last_in_word                      one code point
//  edits     out  variant_index, erase_count, append_length,      one variant edit
//                 char_first, char_second, char_third, final_variant
//
// every code point gives three edits, variants 0, 1, 2 in that order, so the
// single edit channel sets the pace at which the block takes code points
// edits leave one per cycle while the edit channel is ready and code points come
// the first edit of an item passes the input register, then the result register
// reset clears the valid flags, the variant counter and the letter context
// a stalled edit channel holds the result register and, through it, the item
// register; the next code point is taken in the cycle the third edit is loaded
module cyrillic_latin_transliterator_unit
    import cltr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    cltr_sym_if.sink    symbols,
    cltr_edit_if.source edits
);

    item_t      item;
    ctx_t       ctx;
    edit_t      edit;
    logic [1:0] variant;
    logic       item_valid;
    logic       out_free;
    logic       issue;

    // one variant edit moves into the result register whenever an item is held and it has room
    assign issue = item_valid && out_free;

    // holds the code point and the two-letter context, counts variants
    cltr_item_stage u_item_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .symbols    (symbols),
        .issue      (issue),
        .item_valid (item_valid),
        .item       (item),
        .variant    (variant),
        .ctx        (ctx)
    );

    // rom lookups and digraph/trigraph matching for the current variant
    cltr_edit_gen u_edit_gen (
        .item    (item),
        .ctx     (ctx),
        .variant (variant),
        .edit    (edit)
    );

    // result register; frees in the same cycle its edit is taken
    cltr_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_valid (item_valid),
        .edit       (edit),
        .free       (out_free),
        .edits      (edits)
    );

endmodule
